// ===== rtl/clsr_pkg.sv =====
package clsr_pkg;

    // generator word width
    localparam int GEN_W = 31;

    // first generator: 40014 mod 2147483563
    localparam logic [15:0]      MUL_A  = 16'd40014;
    localparam logic [GEN_W-1:0] MOD_A  = 31'd2147483563;
    // 2^31 - MOD_A, used to fold the high part of the product
    localparam logic [7:0]       FOLD_A = 8'd85;

    // second generator: 40692 mod 2147483399
    localparam logic [15:0]      MUL_B  = 16'd40692;
    localparam logic [GEN_W-1:0] MOD_B  = 31'd2147483399;
    localparam logic [7:0]       FOLD_B = 8'd249;

    // wrap span of the output range 1..2147483562
    localparam logic [GEN_W-1:0] WRAP_SPAN = 31'd2147483562;

    // register index of the seed (paddr bit 2)
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_FOLD   = 6'b000100,
        ST_RED    = 6'b001000,
        ST_READ   = 6'b010000,
        ST_FINISH = 6'b100000
    } clsr_state_t;

endpackage

// ===== rtl/clsr_ram.sv =====
module clsr_ram #(
    parameter int DATA_W = 31,
    parameter int DEPTH  = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/combined_lcg_shuffle_random.sv =====
// a draw runs from the input transfer through the unit once per generator, then the read
// and finish states; the input is ready again in the same cycle as the result
// draws do not overlap, each making two passes through the shared
// multiply / fold / reduce unit; a reseed first steps the unit TABLE_ENTRIES + 8 times;
// a result not yet taken holds the draw in its last state until the output frees
// reset: synchronous active low; seed returns to 1, first request reseeds, table not cleared
module combined_lcg_shuffle_random #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] value, [31] zero

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int GW  = clsr_pkg::GEN_W;
    localparam int AW  = $clog2(TABLE_ENTRIES);          // slot index width
    localparam int NW  = $clog2(TABLE_ENTRIES + 8);      // seeding step counter
    localparam int DVW = GW + AW + 1;                    // slot datapath width

    localparam logic [DVW-1:0] DIVISOR  = DVW'(TABLE_ENTRIES) + DVW'(clsr_pkg::WRAP_SPAN);
    // 2^31 minus the divisor, small since the divisor sits just below 2^31
    localparam logic [7:0]     SLOT_FOLD = 8'((64'd1 << GW) - 64'(DIVISOR));
    localparam logic [NW-1:0]  SEED_STEPS_LAST = NW'(TABLE_ENTRIES + 7);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [GW-1:0] seed_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == clsr_pkg::REG_SEED);
    assign prdata    = (paddr[2] == clsr_pkg::REG_SEED) ? {1'b0, seed_reg} : 32'd0;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    clsr_pkg::clsr_state_t state_reg, state_next;

    logic          seeded_reg, seeded_next;
    logic          seeding_reg, seeding_next;     // unit is filling the table
    logic          sel_b_reg, sel_b_next;         // unit works on the second generator
    logic [NW-1:0] step_reg, step_next;           // seeding step, counts down to slot 0

    logic [GW-1:0] first_gen_reg, first_gen_next;
    logic [GW-1:0] second_gen_reg, second_gen_next;
    logic [GW-1:0] last_value_reg, last_value_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [GW-1:0] m_value_reg, m_value_next;

    logic          in_xfer;
    logic          out_free;
    logic [GW-1:0] seed_eff;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign seed_eff = (seed_reg == '0) ? GW'(1) : seed_reg;

    assign s_tready = (state_reg == clsr_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_value_reg};

    // ------------------------------------------------------------------
    // shared modular multiply unit: multiply, fold high part, reduce
    // 2^31 is congruent to FOLD_x, so hi*FOLD_x + lo stays below twice the modulus
    // ------------------------------------------------------------------
    logic [46:0]   prod_reg;
    logic [31:0]   fold_reg;
    logic [GW-1:0] mul_opnd;
    logic [15:0]   mul_const;
    logic [7:0]    fold_const;
    logic [GW-1:0] mod_const;
    logic [31:0]   fold_sum;
    logic [GW-1:0] unit_result;

    assign mul_opnd   = sel_b_reg ? second_gen_reg : first_gen_reg;
    assign mul_const  = sel_b_reg ? clsr_pkg::MUL_B : clsr_pkg::MUL_A;
    assign fold_const = sel_b_reg ? clsr_pkg::FOLD_B : clsr_pkg::FOLD_A;
    assign mod_const  = sel_b_reg ? clsr_pkg::MOD_B : clsr_pkg::MOD_A;

    assign fold_sum = 32'(prod_reg[30:0]) + 32'(prod_reg[46:31]) * 32'(fold_const);
    assign unit_result = (fold_reg >= {1'b0, mod_const})
                       ? GW'(fold_reg - {1'b0, mod_const})
                       : fold_reg[GW-1:0];

    always_ff @(posedge aclk) begin
        prod_reg <= 47'(mul_opnd) * 47'(mul_const);
        fold_reg <= fold_sum;
    end

    // ------------------------------------------------------------------
    // slot index: floor(last * N / (N + span))
    // the top bits of last * N give the quotient or one less; folding them
    // back into the low bits leaves a remainder that settles which
    // registered when a draw enters the unit
    // ------------------------------------------------------------------
    logic [DVW-1:0] slot_num;
    logic [AW:0]    slot_est;
    logic [31:0]    slot_rem;
    logic [AW:0]    slot_quot;
    logic [AW:0]    quot_reg;
    logic           div_load;
    logic [AW-1:0]  slot_idx;

    assign div_load = (state_reg == clsr_pkg::ST_MUL) && !seeding_reg && !sel_b_reg;

    assign slot_num  = DVW'(last_value_reg) * DVW'(TABLE_ENTRIES);
    assign slot_est  = slot_num[DVW-1:GW];
    assign slot_rem  = 32'(slot_num[GW-1:0]) + 32'(slot_est) * 32'(SLOT_FOLD);
    assign slot_quot = (slot_rem >= 32'(DIVISOR)) ? slot_est + (AW + 1)'(1) : slot_est;

    always_ff @(posedge aclk) begin
        if (div_load) begin
            quot_reg <= slot_quot;
        end
    end

    // never out of range in practice, clamped to the last slot anyway
    assign slot_idx = (quot_reg > (AW + 1)'(TABLE_ENTRIES - 1))
                    ? AW'(TABLE_ENTRIES - 1) : quot_reg[AW-1:0];

    // ------------------------------------------------------------------
    // shuffle table
    // ------------------------------------------------------------------
    logic          tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    logic [GW-1:0] tbl_wr_data;
    logic [GW-1:0] tbl_rd_data;

    clsr_ram #(
        .DATA_W (GW),
        .DEPTH  (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (slot_idx),
        .rd_data (tbl_rd_data)
    );

    // slot minus second generator, wrapped into 1..span
    logic [31:0]   diff;
    logic [GW-1:0] draw_value;

    assign diff       = {1'b0, tbl_rd_data} - {1'b0, second_gen_reg};
    assign draw_value = (diff[31] || diff == 32'd0)
                      ? GW'(diff + {1'b0, clsr_pkg::WRAP_SPAN}) : diff[GW-1:0];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        seeded_next     = seeded_reg;
        seeding_next    = seeding_reg;
        sel_b_next      = sel_b_reg;
        step_next       = step_reg;
        first_gen_next  = first_gen_reg;
        second_gen_next = second_gen_reg;
        last_value_next = last_value_reg;
        m_value_next    = m_value_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = slot_idx;
        tbl_wr_data     = first_gen_reg;

        unique case (state_reg)
            clsr_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    sel_b_next = 1'b0;
                    state_next = clsr_pkg::ST_MUL;
                    if (s_tdata[0] || !seeded_reg) begin
                        // both generators start from the seed, then the table fills
                        first_gen_next  = seed_eff;
                        second_gen_next = seed_eff;
                        step_next       = SEED_STEPS_LAST;
                        seeding_next    = 1'b1;
                    end
                end
            end
            clsr_pkg::ST_MUL: begin
                state_next = clsr_pkg::ST_FOLD;
            end
            clsr_pkg::ST_FOLD: begin
                state_next = clsr_pkg::ST_RED;
            end
            clsr_pkg::ST_RED: begin
                state_next = clsr_pkg::ST_MUL;
                if (seeding_reg) begin
                    first_gen_next = unit_result;
                    // the last TABLE_ENTRIES steps land in the table, top slot first
                    if (step_reg < NW'(TABLE_ENTRIES)) begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_addr = step_reg[AW-1:0];
                        tbl_wr_data = unit_result;
                    end
                    if (step_reg == '0) begin
                        last_value_next = unit_result;
                        seeded_next     = 1'b1;
                        seeding_next    = 1'b0;
                    end else begin
                        step_next = step_reg - NW'(1);
                    end
                end else if (!sel_b_reg) begin
                    first_gen_next = unit_result;
                    sel_b_next     = 1'b1;
                end else begin
                    second_gen_next = unit_result;
                    sel_b_next      = 1'b0;
                    state_next      = clsr_pkg::ST_READ;
                end
            end
            clsr_pkg::ST_READ: begin
                // registered table read of the chosen slot
                state_next = clsr_pkg::ST_FINISH;
            end
            clsr_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_value_next    = draw_value;
                    m_tvalid_next   = 1'b1;
                    last_value_next = draw_value;
                    tbl_wr_en       = 1'b1;
                    tbl_wr_addr     = slot_idx;
                    tbl_wr_data     = first_gen_reg;
                    state_next      = clsr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = clsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= clsr_pkg::ST_IDLE;
            seeded_reg   <= 1'b0;
            seeding_reg  <= 1'b0;
            sel_b_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            seed_reg     <= GW'(1);
        end else begin
            state_reg    <= state_next;
            seeded_reg   <= seeded_next;
            seeding_reg  <= seeding_next;
            sel_b_reg    <= sel_b_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_write) begin
                seed_reg <= pwdata[GW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        step_reg       <= step_next;
        first_gen_reg  <= first_gen_next;
        second_gen_reg <= second_gen_next;
        last_value_reg <= last_value_next;
        m_value_reg    <= m_value_next;
    end

endmodule
